@@ rtl/sfcr_pkg.sv @@
// Package with widths, command codes and defaults for the serial flash responder.
`timescale 1ns / 1ps

package sfcr_pkg;

   localparam int DATA_W          = 8;
   localparam int ADDR_W          = 24;
   localparam int STORE_ADDR_BITS = 18;

   localparam logic [DATA_W-1:0] CMD_WREN  = 8'h06;
   localparam logic [DATA_W-1:0] CMD_WRDI  = 8'h04;
   localparam logic [DATA_W-1:0] CMD_RDSR  = 8'h05;
   localparam logic [DATA_W-1:0] CMD_READ  = 8'h03;
   localparam logic [DATA_W-1:0] CMD_FREAD = 8'h0b;
   localparam logic [DATA_W-1:0] CMD_PP    = 8'h02;
   localparam logic [DATA_W-1:0] CMD_PW    = 8'h0a;
   localparam logic [DATA_W-1:0] CMD_RDID  = 8'h9f;

   localparam logic [DATA_W-1:0] STATUS_WEL = 8'h02;
   localparam logic [DATA_W-1:0] STATUS_CLR = 8'h00;
   localparam logic [DATA_W-1:0] ID_BYTE    = 8'hff;

endpackage

@@ rtl/sfcr_if.sv @@
// Request and response channel interfaces for the serial flash responder.
`timescale 1ns / 1ps

interface sfcr_req_if;
   logic                      valid;
   logic                      ready;
   logic [sfcr_pkg::DATA_W-1:0] data_in;
   logic                      hold;

   modport source (output valid, output data_in, output hold, input ready);
   modport sink   (input valid, input data_in, input hold, output ready);
endinterface

interface sfcr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sfcr_pkg::DATA_W-1:0] read_data;
   logic                      read_valid;

   modport source (output valid, output read_data, output read_valid, input ready);
   modport sink   (input valid, input read_data, input read_valid, output ready);
endinterface

@@ rtl/spi_flash_command_responder.sv @@
// Serial flash command responder: one request byte in, one response out, per cycle
// while rsp accepts; each request passes through stage one, then the response register.
// Throughput: one request per cycle while rsp accepts; the store is one byte-wide RAM with
// one registered read port, accessed once per read or program request.
// A response register plus one holding stage absorb two requests while rsp stalls.
// Reset (synchronous, active high) returns to idle and clears write enable and address;
// store contents are undefined until programmed.
`timescale 1ns / 1ps

module spi_flash_command_responder #(
   parameter int STORE_ADDR_BITS = sfcr_pkg::STORE_ADDR_BITS
) (
   input  logic               clock,
   input  logic               reset,
   sfcr_req_if.sink           req_ch,
   sfcr_rsp_if.source         rsp_ch
);

   localparam int DW = sfcr_pkg::DATA_W;
   localparam int AW = sfcr_pkg::ADDR_W;
   localparam int STORE_DEPTH = 1 << STORE_ADDR_BITS;
   localparam logic [AW-1:0] STORE_MASK = AW'((25'd1 << STORE_ADDR_BITS) - 25'd1);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ADDR,
      MODE_READ,
      MODE_PROG,
      MODE_STAT,
      MODE_ID
   } mode_type;

   // Control state
   mode_type         mode_ff, mode_in;
   logic             wel_ff, wel_in;
   logic             is_read_ff, is_read_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [1:0]       addr_cnt_ff, addr_cnt_in;

   // Stage one: request taken, store read in flight
   logic             s1_valid_ff;
   logic             s1_mem_ff;
   logic [DW-1:0]    s1_data_ff;
   logic             s1_rvalid_ff;
   logic             s1_mem_in;
   logic [DW-1:0]    s1_data_in;
   logic             s1_rvalid_in;

   // Response register
   logic             out_valid_ff;
   logic [DW-1:0]    out_data_ff;
   logic             out_rvalid_ff;

   // Store
   logic [DW-1:0]    store_mem [STORE_DEPTH];
   logic [DW-1:0]    mem_q_ff;
   logic             mem_rd;
   logic             mem_wr;

   logic             accept;
   logic             advance;
   logic [AW-1:0]    addr_next;
   logic [1:0]       cnt_next;
   logic [AW-1:0]    addr_shift;

   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign accept        = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.read_data  = out_data_ff;
   assign rsp_ch.read_valid = out_rvalid_ff;

   assign addr_next  = (addr_ff + AW'(1)) & STORE_MASK;
   assign cnt_next   = addr_cnt_ff + 2'd1;
   assign addr_shift = {addr_ff[AW-DW-1:0], req_ch.data_in};

   // Decode the request against the current mode
   always_comb begin
      mode_in      = mode_ff;
      wel_in       = wel_ff;
      is_read_in   = is_read_ff;
      addr_in      = addr_ff;
      addr_cnt_in  = addr_cnt_ff;
      s1_mem_in    = 1'b0;
      s1_data_in   = '0;
      s1_rvalid_in = 1'b0;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            case (req_ch.data_in)
               sfcr_pkg::CMD_WREN: wel_in = 1'b1;
               sfcr_pkg::CMD_WRDI: wel_in = 1'b0;
               sfcr_pkg::CMD_RDSR: mode_in = MODE_STAT;
               sfcr_pkg::CMD_RDID: mode_in = MODE_ID;
               sfcr_pkg::CMD_READ, sfcr_pkg::CMD_FREAD: begin
                  is_read_in  = 1'b1;
                  addr_in     = '0;
                  addr_cnt_in = '0;
                  mode_in     = MODE_ADDR;
               end
               sfcr_pkg::CMD_PP, sfcr_pkg::CMD_PW: begin
                  is_read_in  = 1'b0;
                  addr_in     = '0;
                  addr_cnt_in = '0;
                  mode_in     = MODE_ADDR;
               end
               default: ;
            endcase
         end
         MODE_ADDR: begin
            addr_in     = addr_shift;
            addr_cnt_in = cnt_next;
            if (cnt_next == 2'd3) begin
               addr_cnt_in = '0;
               addr_in     = addr_shift & STORE_MASK;
               mode_in     = is_read_ff ? MODE_READ : MODE_PROG;
            end
         end
         MODE_READ: begin
            mem_rd       = 1'b1;
            s1_mem_in    = 1'b1;
            s1_rvalid_in = 1'b1;
            addr_in      = addr_next;
         end
         MODE_PROG: begin
            mem_wr  = 1'b1;
            addr_in = addr_next;
         end
         MODE_STAT: begin
            s1_data_in   = wel_ff ? sfcr_pkg::STATUS_WEL : sfcr_pkg::STATUS_CLR;
            s1_rvalid_in = 1'b1;
         end
         MODE_ID: begin
            s1_data_in   = sfcr_pkg::ID_BYTE;
            s1_rvalid_in = 1'b1;
         end
         default: ;
      endcase
      // End of transfer drops back to idle
      if (!req_ch.hold) begin
         mode_in = MODE_IDLE;
      end
   end

   // Access the store once per accepted read or program request
   always_ff @(posedge clock) begin
      if (accept && mem_wr) begin
         store_mem[addr_ff[STORE_ADDR_BITS-1:0]] <= req_ch.data_in;
      end
      if (accept && mem_rd) begin
         mem_q_ff <= store_mem[addr_ff[STORE_ADDR_BITS-1:0]];
      end
   end

   // Hold state, advance the pipeline and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         wel_ff       <= 1'b0;
         is_read_ff   <= 1'b0;
         addr_ff      <= '0;
         addr_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            wel_ff       <= wel_in;
            is_read_ff   <= is_read_in;
            addr_ff      <= addr_in;
            addr_cnt_ff  <= addr_cnt_in;
            s1_mem_ff    <= s1_mem_in;
            s1_data_ff   <= s1_data_in;
            s1_rvalid_ff <= s1_rvalid_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= s1_mem_ff ? mem_q_ff : s1_data_ff;
            out_rvalid_ff <= s1_rvalid_ff;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ test/spi_flash_command_responder_test.sv @@
// Self-checking testbench for the serial flash command responder.
`timescale 1ns / 1ps

module spi_flash_command_responder_test;

   localparam int DATA_W          = sfcr_pkg::DATA_W;
   localparam int ADDR_W          = sfcr_pkg::ADDR_W;
   localparam int STORE_ADDR_BITS = sfcr_pkg::STORE_ADDR_BITS;
   localparam int TOTAL_REQUESTS = 1025;
   localparam int LIMIT_CYCLES   = 200000;
   localparam int STORE_SIZE     = 1 << STORE_ADDR_BITS;
   localparam logic [ADDR_W-1:0] STORE_MASK = ADDR_W'(STORE_SIZE - 1);

   typedef enum logic [2:0] {M_IDLE, M_ADDR, M_READ, M_PROG, M_STAT, M_ID} flash_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              read_valid;
   } reply_type;

   // Device-side flash behavior: tracks mode, address and store, queues the replies
   class flash_device_model;
      flash_mode_type    mode = M_IDLE;
      bit                wel_latch = 0;
      bit                reading = 0;
      logic [ADDR_W-1:0] address = '0;
      int unsigned       address_bytes = 0;
      bit [DATA_W-1:0]   store [STORE_SIZE];
      bit                written [STORE_SIZE];
      reply_type         expected_replies [$];
      int unsigned       mismatches = 0;
      int unsigned       requests = 0;
      int unsigned       store_reads = 0;
      int unsigned       program_writes = 0;
      int unsigned       status_replies = 0;
      int unsigned       id_replies = 0;

      function int pending();
         return expected_replies.size();
      endfunction

      // True when this request would leave the device streaming from a blank entry
      function bit leaves_unread_entry(logic [DATA_W-1:0] data, logic hold);
         logic [ADDR_W-1:0] target;
         if (!hold) return 0;
         if (mode == M_ADDR && address_bytes == 2 && reading)
            target = {address[ADDR_W-DATA_W-1:0], data};
         else if (mode == M_READ)
            target = address + 1'b1;
         else
            return 0;
         return !written[target[STORE_ADDR_BITS-1:0]];
      endfunction

      function void take_request(logic [DATA_W-1:0] data, logic hold);
         reply_type reply;
         reply = '0;
         requests++;
         case (mode)
            M_IDLE: begin
               case (data)
                  sfcr_pkg::CMD_WREN: wel_latch = 1;
                  sfcr_pkg::CMD_WRDI: wel_latch = 0;
                  sfcr_pkg::CMD_RDSR: mode = M_STAT;
                  sfcr_pkg::CMD_RDID: mode = M_ID;
                  sfcr_pkg::CMD_READ, sfcr_pkg::CMD_FREAD,
                  sfcr_pkg::CMD_PP, sfcr_pkg::CMD_PW: begin
                     reading = (data == sfcr_pkg::CMD_READ || data == sfcr_pkg::CMD_FREAD);
                     address = '0;
                     address_bytes = 0;
                     mode = M_ADDR;
                  end
                  default: ;
               endcase
            end
            M_ADDR: begin
               // shift in the address, most significant byte first
               address = {address[ADDR_W-DATA_W-1:0], data};
               if (address_bytes == 2) begin
                  address_bytes = 0;
                  address = address & STORE_MASK;
                  mode = reading ? M_READ : M_PROG;
               end else begin
                  address_bytes++;
               end
            end
            M_READ: begin
               reply.read_data = store[address[STORE_ADDR_BITS-1:0]];
               reply.read_valid = 1'b1;
               address = (address + 1'b1) & STORE_MASK;
               store_reads++;
            end
            M_PROG: begin
               store[address[STORE_ADDR_BITS-1:0]] = data;
               written[address[STORE_ADDR_BITS-1:0]] = 1'b1;
               address = (address + 1'b1) & STORE_MASK;
               program_writes++;
            end
            M_STAT: begin
               reply.read_data = wel_latch ? sfcr_pkg::STATUS_WEL : sfcr_pkg::STATUS_CLR;
               reply.read_valid = 1'b1;
               status_replies++;
            end
            M_ID: begin
               reply.read_data = sfcr_pkg::ID_BYTE;
               reply.read_valid = 1'b1;
               id_replies++;
            end
            default: ;
         endcase
         // chip select released: back to command decode
         if (!hold) mode = M_IDLE;
         expected_replies.push_back(reply);
      endfunction

      function void match_response(logic [DATA_W-1:0] data, logic valid_flag);
         reply_type want;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response %02h/%0b arrived with no request pending",
                        $time, data, valid_flag);
            return;
         end
         want = expected_replies.pop_front();
         if (data !== want.read_data || valid_flag !== want.read_valid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: read_data expected %02h got %02h, read_valid expected %0b got %0b",
                        $time, want.read_data, data, want.read_valid, valid_flag);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm = 0;

   sfcr_req_if req_ch ();
   sfcr_rsp_if rsp_ch ();

   flash_device_model board = new();

   spi_flash_command_responder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Offer one request; drop hold rather than stream from a blank store entry
   task automatic send_item(input logic [DATA_W-1:0] data, input logic hold_in,
                            output bit ended);
      logic hold_now;
      hold_now = hold_in;
      if (board.leaves_unread_entry(data, hold_now)) hold_now = 1'b0;
      ended = !hold_now;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.data_in <= data;
      req_ch.hold    <= hold_now;
      do @(posedge clock); while (!req_ch.ready);
      board.take_request(data, hold_now);
   endtask

   // Send one chip-select transfer: hold stays high until the last byte
   task automatic send_transfer(input logic [DATA_W-1:0] bytes [$]);
      bit ended;
      foreach (bytes[i]) begin
         send_item(bytes[i], i != bytes.size() - 1, ended);
         if (ended) break;
      end
   endtask

   // Sink side: check each accepted response, stall in random bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            board.match_response(rsp_ch.read_data, rsp_ch.read_valid);
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      int unsigned cycle_count;
      for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [DATA_W-1:0] bytes [$];
      logic [ADDR_W-1:0] program_starts [$];
      logic [ADDR_W-1:0] start;
      int unsigned       roll;
      int unsigned       count;
      int unsigned       low;
      bit                reading;
      bit                paused;
      bit                ended;

      paused = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.data_in <= '0;
      req_ch.hold    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: status both ways, ID, wrap at the top of the store, fast read,
      // data extremes, unknown command, aborted program
      send_transfer('{sfcr_pkg::CMD_RDSR, 8'h00});
      send_transfer('{sfcr_pkg::CMD_WREN});
      send_transfer('{sfcr_pkg::CMD_RDSR, 8'hff});
      send_transfer('{sfcr_pkg::CMD_RDID, 8'h00});
      send_transfer('{sfcr_pkg::CMD_PW, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff});
      send_transfer('{sfcr_pkg::CMD_READ, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00});
      send_transfer('{sfcr_pkg::CMD_FREAD, 8'h00, 8'h00, 8'h00, 8'h5a});
      send_transfer('{8'hff});
      send_transfer('{sfcr_pkg::CMD_PP, 8'h00});

      // Random: mostly well-formed transfers with random content
      while (board.requests < TOTAL_REQUESTS) begin
         calm = board.requests >= TOTAL_REQUESTS * 85 / 100;
         // hold off once until the device has drained every response
         if (!paused && board.requests >= TOTAL_REQUESTS / 2) begin
            paused = 1;
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (board.pending() != 0) @(posedge clock);
         end
         roll = $urandom_range(0, 99);
         bytes = {};
         if (roll < 65) begin
            reading = (roll < 30) ? 1'b0 : (roll < 58) ? 1'b1 : 1'($urandom_range(0, 1));
            if (program_starts.size() == 0) reading = 1'b0;
            if (reading) begin
               start = program_starts[$urandom_range(0, program_starts.size() - 1)]
                       + ADDR_W'($urandom_range(0, 3));
               bytes.push_back($urandom_range(0, 1) ? sfcr_pkg::CMD_READ : sfcr_pkg::CMD_FREAD);
               count = $urandom_range(0, 20);
            end else begin
               case ($urandom_range(0, 3))
                  0:       low = STORE_SIZE - $urandom_range(1, 8);
                  1:       low = $urandom_range(0, STORE_SIZE - 1);
                  default: low = $urandom_range(0, 255);
               endcase
               start = ADDR_W'(low);
               bytes.push_back($urandom_range(0, 1) ? sfcr_pkg::CMD_PP : sfcr_pkg::CMD_PW);
               count = $urandom_range(1, 16);
               program_starts.push_back(start);
               if (program_starts.size() > 64) void'(program_starts.pop_front());
            end
            // upper address bits lie outside the store and are ignored
            start = (ADDR_W'($urandom) & ~STORE_MASK) | (start & STORE_MASK);
            bytes.push_back(start[23:16]);
            bytes.push_back(start[15:8]);
            bytes.push_back(start[7:0]);
            repeat (count) bytes.push_back(DATA_W'($urandom));
            // broken transfer: release chip select early
            if (roll >= 58) bytes = bytes[0:$urandom_range(0, 2)];
            send_transfer(bytes);
         end else if (roll < 82) begin
            bytes.push_back(roll < 75 ? sfcr_pkg::CMD_RDSR : sfcr_pkg::CMD_RDID);
            repeat ($urandom_range(0, 4)) bytes.push_back(DATA_W'($urandom));
            send_transfer(bytes);
         end else if (roll < 90) begin
            send_transfer('{$urandom_range(0, 1) ? sfcr_pkg::CMD_WREN : sfcr_pkg::CMD_WRDI});
         end else begin
            send_item(DATA_W'($urandom), 1'($urandom_range(0, 1)), ended);
         end
      end

      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d requests: %0d store reads, %0d program writes,",
               board.requests, board.store_reads, board.program_writes);
      $display("%0d status replies and %0d ID replies; %0d mismatches seen.",
               board.status_replies, board.id_replies, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
